@@ src/kmc_pkg.sv @@
// Shared types and constants for the knob and tap menu controller.
package kmc_pkg;

	localparam int SAMPLE_W = 12;

	typedef enum logic [2:0] {
		SCR_HOME      = 3'd0,
		SCR_MENU      = 3'd1,
		SCR_TIMER     = 3'd2,
		SCR_STOPWATCH = 3'd3,
		SCR_ALARM     = 3'd4,
		SCR_WEATHER   = 3'd5,
		SCR_MEDIA     = 3'd6,
		SCR_STATS     = 3'd7
	} screen_t;

	localparam logic [2:0] CFG_OPEN_TH     = 3'd0;
	localparam logic [2:0] CFG_STEP_TH     = 3'd1;
	localparam logic [2:0] CFG_STEP_INT    = 3'd2;
	localparam logic [2:0] CFG_TAP_WIN     = 3'd3;
	localparam logic [2:0] CFG_MENU_TMO    = 3'd4;
	localparam logic [2:0] CFG_VOL_DBAND   = 3'd5;

	localparam logic [11:0] OPEN_TH_RST   = 12'd250;
	localparam logic [11:0] STEP_TH_RST   = 12'd200;
	localparam logic [15:0] STEP_INT_RST  = 16'd150;
	localparam logic [15:0] TAP_WIN_RST   = 16'd250;
	localparam logic [15:0] MENU_TMO_RST  = 16'd3000;
	localparam logic [6:0]  VOL_DBAND_RST = 7'd5;
	localparam logic [6:0]  VOL_RST       = 7'd50;
	localparam logic [6:0]  VOL_MAX       = 7'd100;

	// level*100/4095 as a multiply by a scaled reciprocal, exact for 12-bit levels
	localparam logic [20:0] VOL_RECIP = 21'd1638801;
	localparam int          VOL_SHIFT = 26;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [11:0] knob_sample;
		logic        touch_level;
	} in_t;

	typedef struct packed {
		logic [2:0]  screen;
		logic [2:0]  menu_index;
		logic [1:0]  menu_top;
		logic [6:0]  volume;
		logic        volume_request;
		logic        toggle_request;
		logic        playing;
		logic [11:0] smoothed_level;
	} out_t;

	typedef struct packed {
		logic [11:0] open_threshold;
		logic [11:0] step_threshold;
		logic [15:0] step_interval_ms;
		logic [15:0] tap_window_ms;
		logic [15:0] menu_timeout_ms;
		logic [6:0]  volume_deadband;
	} cfg_t;

endpackage

@@ src/knob_and_tap_menu_controller_core.sv @@
// Top level: request handshake, configuration registers, input and result registers.
// Takes one tick request per clock unless stalled and returns exactly one result per tick. The window update
// and average of a tick are registered when its request is taken, and the control logic between
// that stage and the result register is combinational, so a result is registered when that stage
// advances; throughput is one per cycle while the consumer takes results, and the result register
// holds its output while the consumer stalls. Configuration writes take effect on the next
// cycle and should only be made while no tick is in flight.
module knob_and_tap_menu_controller_core #(
	parameter int WINDOW_LEN = 5,
	parameter int MENU_ITEMS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  kmc_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output kmc_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_wdata
);
	import kmc_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [31:0] now_s1;
	logic        touch_s1;
	logic [11:0] avg_s1;
	logic        first_s1;
	logic        adv;
	logic        accept;
	out_t        res;
	out_t        out_q;
	logic        out_valid_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_threshold   <= OPEN_TH_RST;
			cfg_q.step_threshold   <= STEP_TH_RST;
			cfg_q.step_interval_ms <= STEP_INT_RST;
			cfg_q.tap_window_ms    <= TAP_WIN_RST;
			cfg_q.menu_timeout_ms  <= MENU_TMO_RST;
			cfg_q.volume_deadband  <= VOL_DBAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_TH:   cfg_q.open_threshold   <= cfg_wdata[11:0];
				CFG_STEP_TH:   cfg_q.step_threshold   <= cfg_wdata[11:0];
				CFG_STEP_INT:  cfg_q.step_interval_ms <= cfg_wdata;
				CFG_TAP_WIN:   cfg_q.tap_window_ms    <= cfg_wdata;
				CFG_MENU_TMO:  cfg_q.menu_timeout_ms  <= cfg_wdata;
				CFG_VOL_DBAND: cfg_q.volume_deadband  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_s1   <= in_data.now_ms;
			touch_s1 <= in_data.touch_level;
		end
		if (adv) out_q <= res;
	end

	kmc_smooth #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_smooth (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (in_data.knob_sample),
		.avg_s1   (avg_s1),
		.first_s1 (first_s1)
	);

	kmc_ctrl #(
		.MENU_ITEMS(MENU_ITEMS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.now_ms      (now_s1),
		.touch_level (touch_s1),
		.avg         (avg_s1),
		.first       (first_s1),
		.cfg         (cfg_q),
		.res         (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ src/kmc_smooth.sv @@
// Knob moving-average window with running sum; registers the average for the control stage.
module kmc_smooth #(
	parameter int WINDOW_LEN = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [11:0] sample,
	output logic [11:0] avg_s1,
	output logic        first_s1
);
	import kmc_pkg::*;

	localparam int POS_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int SH      = SUM_W + $clog2(WINDOW_LEN) + 1;
	localparam longint RECIP_L = ((64'd1 << SH) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam logic [SH:0] RECIP = RECIP_L[SH:0];
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_LEN - 1);
	localparam logic [SUM_W-1:0] WLEN = SUM_W'(WINDOW_LEN);

	logic [11:0]          win_q [WINDOW_LEN];
	logic [POS_W-1:0]     pos_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 primed_q;
	logic [SUM_W-1:0]     sum_next;
	logic [SUM_W+SH:0]    prod;
	logic [11:0]          avg_next;
	logic [POS_W-1:0]     pos_next;

	always_comb begin
		if (!primed_q) begin
			sum_next = SUM_W'(WLEN * {{(SUM_W-12){1'b0}}, sample});
		end else begin
			sum_next = sum_q - {{(SUM_W-12){1'b0}}, win_q[pos_q]} + {{(SUM_W-12){1'b0}}, sample};
		end
		prod     = {{(SH+1){1'b0}}, sum_next} * {{SUM_W{1'b0}}, RECIP};
		avg_next = prod[SH +: 12];
		pos_next = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_next;
			sum_q    <= sum_next;
			primed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				if (!primed_q || pos_q == POS_W'(i)) begin
					win_q[i] <= sample;
				end
			end
			avg_s1   <= avg_next;
			first_s1 <= !primed_q;
		end
	end

endmodule

@@ src/kmc_ctrl.sv @@
// Screen, menu, tap and volume state machine; one tick evaluated per step.
module kmc_ctrl #(
	parameter int MENU_ITEMS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [31:0]    now_ms,
	input  logic           touch_level,
	input  logic [11:0]    avg,
	input  logic           first,
	input  kmc_pkg::cfg_t  cfg,
	output kmc_pkg::out_t  res
);
	import kmc_pkg::*;

	localparam logic [2:0] LAST_IDX = 3'(MENU_ITEMS - 1);

	screen_t     screen_q, scr;
	logic [2:0]  idx_q, idx;
	logic [1:0]  top_q, top;
	logic [11:0] level_q, lvl, last;
	logic [31:0] act_q, act, stp_q, stp, tap_q, tap;
	logic [1:0]  cnt_q, cnt;
	logic        prev_touch_q;
	logic [6:0]  vol_q, vol;
	logic        playing_q, play;
	logic        vreq, treq, opened;
	logic [11:0] open_diff;
	logic [32:0] vol_prod;
	logic [6:0]  vol_calc, vol_diff;

	always_comb begin
		last      = first ? avg : level_q;
		scr       = screen_q;
		idx       = idx_q;
		top       = top_q;
		lvl       = last;
		act       = act_q;
		stp       = stp_q;
		tap       = tap_q;
		cnt       = cnt_q;
		vol       = vol_q;
		play      = playing_q;
		vreq      = 1'b0;
		treq      = 1'b0;
		opened    = 1'b0;
		open_diff = (avg > last) ? avg - last : last - avg;
		vol_prod  = {9'b0, avg} * {12'b0, VOL_RECIP};
		vol_calc  = vol_prod[VOL_SHIFT +: 7];
		vol_diff  = (vol_calc > vol_q) ? vol_calc - vol_q : vol_q - vol_calc;

		if (scr == SCR_HOME && open_diff > cfg.open_threshold) begin
			scr    = SCR_MENU;
			act    = now_ms;
			lvl    = avg;
			opened = 1'b1;
		end

		if (!opened) begin
			if (scr == SCR_MENU) begin
				if ((now_ms - stp_q) > {16'b0, cfg.step_interval_ms}) begin
					if ({1'b0, avg} > {1'b0, last} + {1'b0, cfg.step_threshold}) begin
						if (idx < LAST_IDX) idx = idx + 3'd1;
					end else if ({1'b0, avg} + {1'b0, cfg.step_threshold} < {1'b0, last}) begin
						if (idx != 3'd0) idx = idx - 3'd1;
					end
					lvl = avg;
					act = now_ms;
					stp = now_ms;
				end
				if ({1'b0, idx} >= {2'b0, top} + 4'd3) top = 2'(idx - 3'd2);
				if (idx < {1'b0, top}) top = idx[1:0];
			end
			if (scr == SCR_MEDIA && vol_diff > cfg.volume_deadband) begin
				vol  = vol_calc;
				vreq = 1'b1;
			end
		end

		if (touch_level && !prev_touch_q) begin
			if (cnt != 2'd3) cnt = cnt + 2'd1;
			tap = now_ms;
			act = now_ms;
		end

		if ((now_ms - tap) > {16'b0, cfg.tap_window_ms} && cnt != 2'd0) begin
			case (cnt)
				2'd1: begin
					if (scr == SCR_MEDIA) begin
						treq = 1'b1;
						play = !play;
					end else if (scr == SCR_MENU) begin
						scr = screen_t'(idx + 3'd2);
					end
				end
				2'd2: begin
					if (scr == SCR_MENU) scr = SCR_HOME;
					else if (scr != SCR_HOME) scr = SCR_MENU;
				end
				default: ;
			endcase
			cnt = 2'd0;
		end

		if (scr == SCR_MENU && (now_ms - act) > {16'b0, cfg.menu_timeout_ms}) scr = SCR_HOME;
	end

	always_comb begin
		res.screen         = scr;
		res.menu_index     = idx;
		res.menu_top       = top;
		res.volume         = vol;
		res.volume_request = vreq;
		res.toggle_request = treq;
		res.playing        = play;
		res.smoothed_level = avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q     <= SCR_HOME;
			idx_q        <= '0;
			top_q        <= '0;
			level_q      <= '0;
			act_q        <= '0;
			stp_q        <= '0;
			tap_q        <= '0;
			cnt_q        <= '0;
			prev_touch_q <= 1'b0;
			vol_q        <= VOL_RST;
			playing_q    <= 1'b0;
		end else if (step) begin
			screen_q     <= scr;
			idx_q        <= idx;
			top_q        <= top;
			level_q      <= lvl;
			act_q        <= act;
			stp_q        <= stp;
			tap_q        <= tap;
			cnt_q        <= cnt;
			prev_touch_q <= touch_level;
			vol_q        <= vol;
			playing_q    <= play;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX) else $error("menu index out of range");

	a_top_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, top_q} <= idx_q && {1'b0, idx_q} <= {2'b0, top_q} + 4'd2)
		else $error("highlighted entry outside visible rows");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		vol_q <= VOL_MAX) else $error("volume above maximum");

	a_play_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && treq) |=> $stable(playing_q)) else $error("playing changed without toggle");

	a_vol_req: assert property (@(posedge clk) disable iff (!arst_n)
		step && vreq |-> screen_q == SCR_MEDIA) else $error("volume request off media screen");

endmodule
